// File: rtl/mwrs_pkg.sv
package mwrs_pkg;

  localparam int unsigned WINDOW_DEPTH = 1024;
  localparam int unsigned VALUE_BITS   = 16;
  localparam int unsigned TARGET_W     = 32;

  localparam int unsigned PTR_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  // largest sum is WINDOW_DEPTH * (2^VALUE_BITS - 1)
  localparam int unsigned SUM_W = VALUE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  localparam int unsigned IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((CNT_W + 1 + 7) / 8) * 8;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_DROP_RD = 6'b000010,
    S_DROP    = 6'b000100,
    S_APPEND  = 6'b001000,
    S_CHECK   = 6'b010000,
    S_REM     = 6'b100000
  } state_e;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(WINDOW_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// File: rtl/min_window_length_reaching_sum.sv
// Channel   | Dir | Handshake                 | Payload
// s_axis    | in  | s_axis_tvalid/tready      | tdata[15:0] sample_value, tlast last_item
// m_axis    | out | m_axis_tvalid/tready      | tdata[10:0] shortest_length, [11] overflow
// cfg       | in  | cfg_valid_i/cfg_ready_o   | cfg_data_i[31:0] target_sum
//
// An item passes accept (S_IDLE) and compare (S_CHECK), plus S_REM and S_CHECK per value
// dropped from the oldest end; each drop is a registered read of the window store then a subtract.
// An item arriving on a full window first passes S_DROP_RD, S_DROP and S_APPEND for the forced drop.
// A last item holds in the compare state until the output register is free.
// Reset clears pointers, count, sum and the overflow and output-valid flags; the store itself is never cleared.
// The next item is accepted while a result waits in the output register.
module min_window_length_reaching_sum
  import mwrs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] sample_value
  input  logic                   s_axis_tlast,   // last_item
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [10:0] shortest_length, [11] window_overflow
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [TARGET_W-1:0]    cfg_data_i
);

  state_e                state_q, state_d;
  logic [TARGET_W-1:0]   target_q, target_d;
  logic [PTR_W-1:0]      oldest_q, oldest_d;
  logic [PTR_W-1:0]      newest_q, newest_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [CNT_W-1:0]      best_q, best_d;
  logic                  ovf_q, ovf_d;
  logic                  last_q, last_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  out_valid_q, out_valid_d;
  logic [CNT_W-1:0]      out_len_q, out_len_d;
  logic                  out_ovf_q, out_ovf_d;

  logic [VALUE_BITS-1:0] window_store [WINDOW_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_q;
  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_data;

  logic in_xfer, out_free, full, reached;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (count_q == CNT_W'(WINDOW_DEPTH));
  assign reached       = (count_q != '0) && (CMP_W'(sum_q) >= CMP_W'(target_q));
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d     = state_q;
    target_d    = target_q;
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    count_d     = count_q;
    sum_d       = sum_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_len_d   = out_len_q;
    out_ovf_d   = out_ovf_q;
    wr_en       = 1'b0;
    wr_data     = val_q;

    if (cfg_valid_i) begin
      target_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          val_d  = s_axis_tdata[VALUE_BITS-1:0];
          last_d = s_axis_tlast;
          if (full) begin
            state_d = S_DROP_RD;
          end else begin
            // common case: append in the accept cycle
            wr_en    = 1'b1;
            wr_data  = s_axis_tdata[VALUE_BITS-1:0];
            newest_d = ptr_next(newest_q);
            count_d  = count_q + CNT_W'(1);
            sum_d    = sum_q + SUM_W'(s_axis_tdata[VALUE_BITS-1:0]);
            state_d  = S_CHECK;
          end
        end
      end
      S_DROP_RD: begin
        state_d = S_DROP;
      end
      S_DROP: begin
        sum_d    = sum_q - SUM_W'(rd_data_q);
        oldest_d = ptr_next(oldest_q);
        count_d  = count_q - CNT_W'(1);
        ovf_d    = 1'b1;
        state_d  = S_APPEND;
      end
      S_APPEND: begin
        wr_en    = 1'b1;
        newest_d = ptr_next(newest_q);
        count_d  = count_q + CNT_W'(1);
        sum_d    = sum_q + SUM_W'(val_q);
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (reached) begin
          if (best_q == '0 || count_q < best_q) begin
            best_d = count_q;
          end
          state_d = S_REM;
        end else if (!last_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_len_d   = best_q;
          out_ovf_d   = ovf_q;
          oldest_d    = '0;
          newest_d    = '0;
          count_d     = '0;
          sum_d       = '0;
          best_d      = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      S_REM: begin
        sum_d    = sum_q - SUM_W'(rd_data_q);
        oldest_d = ptr_next(oldest_q);
        count_d  = count_q - CNT_W'(1);
        state_d  = S_CHECK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      target_q    <= TARGET_W'(1);
      oldest_q    <= '0;
      newest_q    <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      target_q    <= target_d;
      oldest_q    <= oldest_d;
      newest_q    <= newest_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q    <= last_d;
    val_q     <= val_d;
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
  end

  // window store: one write port at the newest slot, read always at the oldest slot
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      window_store[newest_q] <= wr_data;
    end
    rd_data_q <= window_store[oldest_q];
  end

  assign m_axis_tvalid = out_valid_q;
  always_comb begin
    m_axis_tdata          = '0;
    m_axis_tdata[CNT_W-1:0] = out_len_q;
    m_axis_tdata[CNT_W]   = out_ovf_q;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_DEPTH))
    else $error("window count exceeds depth");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> (sum_q == '0 && oldest_q == newest_q))
    else $error("empty window with nonzero sum or pointer skew");

  a_idle_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !reached)
    else $error("idle with a window still reaching target");

  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q <= CNT_W'(WINDOW_DEPTH))
    else $error("best length out of range");

  a_drop_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DROP |-> full)
    else $error("forced drop without a full window");

endmodule
